[hw/rtl/ptsu_pkg.sv]
// Shared types and constants of the priority thread scheduler unit.
// Holds action, status and placement codes, field widths and the tick unit request.
// No dependencies.
package ptsu_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int PRIO_LEVELS_DEF = 4;

    localparam int ACTION_W  = 3;
    localparam int THREAD_W  = 4;
    localparam int PRIO_W    = 2;
    localparam int DELAY_W   = 16;
    localparam int NOW_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int RATE_W    = 10;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_ADDR_W = 3;

    // Register indexes, decoded from paddr bit 2.
    localparam logic REG_DEFAULT_PRIO = 1'b0;
    localparam logic REG_TICK_RATE    = 1'b1;

    localparam logic [PRIO_W-1:0] DEFAULT_PRIO_RST = 2'd1;
    localparam logic [RATE_W-1:0] TICK_RATE_RST    = 10'd60;

    // Division by 1000 as a multiply by a rounded-up reciprocal and one correction.
    localparam int               MS_PER_SEC  = 1000;
    localparam int               RECIP_SHIFT = 36;
    localparam logic [26:0]      RECIP_MULT  = 27'd68719477;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE    = 3'd0,
        ACT_YIELD     = 3'd1,
        ACT_SLEEP     = 3'd2,
        ACT_WAKE      = 3'd3,
        ACT_TERMINATE = 3'd4,
        ACT_SETPRIO   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_THREAD = 2'd1,
        ST_SELF_TERM = 2'd2,
        ST_QUEUED    = 2'd3
    } status_t;

    localparam logic [1:0] PL_UNQUEUED = 2'd0;
    localparam logic [1:0] PL_READY    = 2'd1;
    localparam logic [1:0] PL_SLEEPING = 2'd2;
    localparam logic [1:0] PL_RUNNING  = 2'd3;

    typedef struct packed {
        logic                start;
        logic [DELAY_W-1:0]  delay_ms;
        logic [RATE_W-1:0]   rate;
        logic [NOW_W-1:0]    now;
    } tick_req_t;

endpackage

[hw/rtl/ptsu_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ptsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ptsu_ticks.sv]
// Four-stage unit that turns a sleep length in milliseconds into a wake tick.
// Depends on ptsu_pkg for the request type and the reciprocal constants.
module ptsu_ticks import ptsu_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  tick_req_t        req,
    output logic             done,
    output logic [NOW_W-1:0] wake_at
);

    logic [3:0]       vld_reg;
    logic [25:0]      prod_reg;
    logic [52:0]      scaled_reg;
    logic [25:0]      prod2_reg;
    logic [16:0]      ticks_reg;
    logic [NOW_W-1:0] now1_reg, now2_reg, now3_reg;
    logic [NOW_W-1:0] wake_reg;

    logic [16:0] quot_est;
    logic [26:0] quot_back;
    logic [16:0] quot;
    logic [NOW_W:0] wake_sum;

    always_comb
    begin
        quot_est  = scaled_reg[RECIP_SHIFT +: 17];
        quot_back = 27'(quot_est) * 27'(MS_PER_SEC);
        // The rounded-up reciprocal overshoots by at most one.
        quot      = (quot_back > 27'(prod2_reg)) ? quot_est - 17'd1 : quot_est;
        wake_sum  = {1'b0, now3_reg} + (NOW_W + 1)'(ticks_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= 26'(req.delay_ms) * 26'(req.rate);
        now1_reg   <= req.now;
        scaled_reg <= 53'(prod_reg) * 53'(RECIP_MULT);
        prod2_reg  <= prod_reg;
        now2_reg   <= now1_reg;
        ticks_reg  <= (quot == 17'd0) ? 17'd1 : quot;
        now3_reg   <= now2_reg;
        wake_reg   <= wake_sum[NOW_W] ? '1 : wake_sum[NOW_W-1:0];
    end

    assign done    = vld_reg[3];
    assign wake_at = wake_reg;

endmodule

[hw/rtl/priority_thread_scheduler_unit.sv]
// Strict-priority thread scheduler: per-level FIFO ready queues and a sleep list.
// Wake and terminate walk their list one entry at a time, since every link costs one read
// of the link memory.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: all queues empty, thread 0 running, default priority 1, tick rate 60.
// Depends on ptsu_pkg, ptsu_ram and ptsu_ticks.
module priority_thread_scheduler_unit import ptsu_pkg::*; #(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // action[2:0], thread[6:3], priority_req[8:7], delay_ms[24:9], now[56:25]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // running_thread[3:0], status[5:4]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int TW = $clog2(MAX_THREADS);
    localparam int NW = TW + 1;
    localparam int LW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam logic [NW-1:0] NIL = NW'(MAX_THREADS);
    localparam logic [LW-1:0] RESET_LVL = (PRIO_LEVELS > 1) ? LW'(1) : LW'(0);

    typedef struct packed {
        logic [NOW_W-1:0] wake;
        logic [LW-1:0]    lv;
        logic [1:0]       plc;
    } info_t;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_C_CHK = 17'h00002,
        S_YIELD = 17'h00004,
        S_Y_CHK = 17'h00008,
        S_AP1   = 17'h00010,
        S_AP2   = 17'h00020,
        S_PICK  = 17'h00040,
        S_PK2   = 17'h00080,
        S_SL_M  = 17'h00100,
        S_SL_W  = 17'h00200,
        S_W_RD  = 17'h00400,
        S_W_CHK = 17'h00800,
        S_T_CHK = 17'h01000,
        S_U_RD  = 17'h02000,
        S_U_CHK = 17'h04000,
        S_U_FIN = 17'h08000,
        S_DONE  = 17'h10000
    } state_t;

    function automatic logic [LW-1:0] clamp_lvl(input logic [31:0] v);
        clamp_lvl = (v < 32'(PRIO_LEVELS)) ? LW'(v) : LW'(PRIO_LEVELS - 1);
    endfunction

    // Input field views.
    logic [ACTION_W-1:0] in_action;
    logic [THREAD_W-1:0] in_thread;
    logic [PRIO_W-1:0]   in_prio;
    logic [DELAY_W-1:0]  in_delay;
    logic [NOW_W-1:0]    in_now;

    assign in_action = s_axis_tdata[2:0];
    assign in_thread = s_axis_tdata[6:3];
    assign in_prio   = s_axis_tdata[8:7];
    assign in_delay  = s_axis_tdata[24:9];
    assign in_now    = s_axis_tdata[56:25];

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [PRIO_W-1:0]   dprio_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [THREAD_W-1:0] th_raw_reg, th_raw_next;
    logic [TW-1:0]       th_reg, th_next;
    logic [PRIO_W-1:0]   preq_reg, preq_next;
    logic [NOW_W-1:0]    now_reg, now_next;

    logic [NW-1:0] head_reg [PRIO_LEVELS];
    logic [NW-1:0] head_next [PRIO_LEVELS];
    logic [NW-1:0] tail_reg [PRIO_LEVELS];
    logic [NW-1:0] tail_next [PRIO_LEVELS];
    logic [NW-1:0] sleep_head_reg, sleep_head_next;
    logic [TW-1:0] running_reg, running_next;
    logic          rv_reg, rv_next;

    logic [TW-1:0]    ap_t_reg, ap_t_next;
    logic [LW-1:0]    ap_lv_reg, ap_lv_next;
    logic [NOW_W-1:0] ap_wake_reg, ap_wake_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    prev_reg, prev_next;
    logic [NW-1:0]    guard_reg, guard_next;
    logic             u_ready_reg, u_ready_next;
    status_t          status_reg, status_next;
    logic             report_reg, report_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [MAX_THREADS-1:0] inf_vld_reg, inf_vld_next;
    logic [MAX_THREADS-1:0] lnk_vld_reg, lnk_vld_next;
    logic                   inf_rv_reg, lnk_rv_reg;
    logic [TW-1:0]          inf_ra_reg;

    logic          inf_we, lnk_we;
    logic [TW-1:0] inf_waddr, inf_raddr, lnk_waddr, lnk_raddr;
    info_t         inf_wdata, inf_rdata, inf_eff;
    logic [NW-1:0] lnk_wdata, lnk_rdata, lnk_eff;

    tick_req_t        tick_req;
    logic             tick_done;
    logic [NOW_W-1:0] tick_wake;

    logic          s_accept, apb_wr;
    logic          th_ok, pick_found, cur_nil, guard_end;
    logic [LW-1:0] pick_lv;
    logic          ht_ok;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pready        = 1'b1;
    assign apb_wr        = psel && penable && pwrite;
    assign prdata        = (paddr[2] == REG_TICK_RATE) ? 32'(rate_reg) : 32'(dprio_reg);

    ptsu_ram #(.WIDTH($bits(info_t)), .DEPTH(MAX_THREADS)) u_info_ram (
        .clk   (clk),
        .we    (inf_we),
        .waddr (inf_waddr),
        .wdata (inf_wdata),
        .raddr (inf_raddr),
        .rdata (inf_rdata)
    );

    ptsu_ram #(.WIDTH(NW), .DEPTH(MAX_THREADS)) u_link_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    ptsu_ticks u_ticks (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tick_req),
        .done    (tick_done),
        .wake_at (tick_wake)
    );

    // Entries never written read as their reset contents.
    always_comb
    begin
        if (inf_rv_reg)
        begin
            inf_eff = inf_rdata;
        end
        else
        begin
            inf_eff.wake = '0;
            inf_eff.lv   = RESET_LVL;
            inf_eff.plc  = (inf_ra_reg == '0) ? PL_RUNNING : PL_UNQUEUED;
        end
        lnk_eff = lnk_rv_reg ? lnk_rdata : NIL;
    end

    always_comb
    begin
        pick_found = 1'b0;
        pick_lv    = '0;
        ht_ok      = 1'b1;
        for (int i = 0; i < PRIO_LEVELS; i++)
        begin
            if (head_reg[i] != NIL)
            begin
                pick_found = 1'b1;
                pick_lv    = LW'(i);
            end
            ht_ok = ht_ok && ((head_reg[i] == NIL) == (tail_reg[i] == NIL));
        end
    end

    assign th_ok     = (32'(in_thread) < 32'(MAX_THREADS));
    assign cur_nil   = (cur_reg >= NIL);
    assign guard_end = (guard_reg == NW'(MAX_THREADS));

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        act_next        = act_reg;
        th_raw_next     = th_raw_reg;
        th_next         = th_reg;
        preq_next       = preq_reg;
        now_next        = now_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        sleep_head_next = sleep_head_reg;
        running_next    = running_reg;
        rv_next         = rv_reg;
        ap_t_next       = ap_t_reg;
        ap_lv_next      = ap_lv_reg;
        ap_wake_next    = ap_wake_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        guard_next      = guard_reg;
        u_ready_next    = u_ready_reg;
        status_next     = status_reg;
        report_next     = report_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        inf_we    = 1'b0;
        inf_waddr = ap_t_reg;
        inf_wdata = '0;
        inf_raddr = '0;
        lnk_we    = 1'b0;
        lnk_waddr = ap_t_reg;
        lnk_wdata = NIL;
        lnk_raddr = '0;

        tick_req.start    = 1'b0;
        tick_req.delay_ms = in_delay;
        tick_req.rate     = rate_reg;
        tick_req.now      = in_now;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    act_next    = in_action;
                    th_raw_next = in_thread;
                    th_next     = TW'(in_thread);
                    preq_next   = in_prio;
                    now_next    = in_now;
                    report_next = 1'b0;
                    status_next = ST_OK;
                    unique case (action_t'(in_action))
                        ACT_CREATE:
                        begin
                            inf_raddr  = TW'(in_thread);
                            state_next = th_ok ? S_C_CHK : S_DONE;
                        end
                        ACT_YIELD, ACT_SETPRIO:
                        begin
                            state_next = S_YIELD;
                        end
                        ACT_SLEEP:
                        begin
                            tick_req.start = rv_reg;
                            state_next     = rv_reg ? S_SL_M : S_PICK;
                        end
                        ACT_WAKE:
                        begin
                            cur_next        = sleep_head_reg;
                            sleep_head_next = NIL;
                            guard_next      = '0;
                            state_next      = S_W_RD;
                        end
                        ACT_TERMINATE:
                        begin
                            inf_raddr  = TW'(in_thread);
                            state_next = th_ok ? S_T_CHK : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_C_CHK:
            begin
                if (inf_eff.plc != PL_UNQUEUED &&
                    (inf_eff.plc != PL_RUNNING || (rv_reg && running_reg == th_reg)))
                begin
                    status_next = ST_QUEUED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ap_t_next    = th_reg;
                    ap_lv_next   = clamp_lvl(32'(dprio_reg));
                    ap_wake_next = inf_eff.wake;
                    ret_next     = S_DONE;
                    state_next   = S_AP1;
                end
            end

            S_YIELD:
            begin
                inf_raddr  = running_reg;
                state_next = rv_reg ? S_Y_CHK : S_PICK;
            end

            S_Y_CHK:
            begin
                ap_t_next    = running_reg;
                ap_lv_next   = (action_t'(act_reg) == ACT_SETPRIO) ?
                               clamp_lvl(32'(preq_reg)) : inf_eff.lv;
                ap_wake_next = inf_eff.wake;
                ret_next     = S_PICK;
                state_next   = S_AP1;
            end

            // Append ap_t at the tail of its level.
            S_AP1:
            begin
                inf_we         = 1'b1;
                inf_waddr      = ap_t_reg;
                inf_wdata.wake = ap_wake_reg;
                inf_wdata.lv   = ap_lv_reg;
                inf_wdata.plc  = PL_READY;
                lnk_we         = 1'b1;
                lnk_waddr      = ap_t_reg;
                lnk_wdata      = NIL;
                if (head_reg[ap_lv_reg] == NIL)
                begin
                    head_next[ap_lv_reg] = NW'(ap_t_reg);
                    tail_next[ap_lv_reg] = NW'(ap_t_reg);
                    state_next           = ret_reg;
                end
                else
                begin
                    state_next = S_AP2;
                end
            end

            S_AP2:
            begin
                lnk_we               = 1'b1;
                lnk_waddr            = TW'(tail_reg[ap_lv_reg]);
                lnk_wdata            = NW'(ap_t_reg);
                tail_next[ap_lv_reg] = NW'(ap_t_reg);
                state_next           = ret_reg;
            end

            S_PICK:
            begin
                if (pick_found)
                begin
                    ap_lv_next = pick_lv;
                    ap_t_next  = TW'(head_reg[pick_lv]);
                    inf_raddr  = TW'(head_reg[pick_lv]);
                    lnk_raddr  = TW'(head_reg[pick_lv]);
                    state_next = S_PK2;
                end
                else
                begin
                    rv_next     = 1'b0;
                    status_next = ST_NO_THREAD;
                    state_next  = S_DONE;
                end
            end

            S_PK2:
            begin
                head_next[ap_lv_reg] = lnk_eff;
                if (lnk_eff >= NIL)
                begin
                    tail_next[ap_lv_reg] = NIL;
                end
                lnk_we         = 1'b1;
                lnk_waddr      = ap_t_reg;
                lnk_wdata      = NIL;
                inf_we         = 1'b1;
                inf_waddr      = ap_t_reg;
                inf_wdata.wake = inf_eff.wake;
                inf_wdata.lv   = inf_eff.lv;
                inf_wdata.plc  = PL_RUNNING;
                running_next   = ap_t_reg;
                rv_next        = 1'b1;
                status_next    = ST_OK;
                state_next     = S_DONE;
            end

            // The tick unit keeps computing on the live bus, so its answer is held here.
            S_SL_M:
            begin
                if (tick_done)
                begin
                    ap_wake_next = tick_wake;
                    inf_raddr    = running_reg;
                    state_next   = S_SL_W;
                end
            end

            S_SL_W:
            begin
                inf_we          = 1'b1;
                inf_waddr       = running_reg;
                inf_wdata.wake  = ap_wake_reg;
                inf_wdata.lv    = inf_eff.lv;
                inf_wdata.plc   = PL_SLEEPING;
                lnk_we          = 1'b1;
                lnk_waddr       = running_reg;
                lnk_wdata       = sleep_head_reg;
                sleep_head_next = NW'(running_reg);
                rv_next         = 1'b0;
                state_next      = S_PICK;
            end

            S_W_RD:
            begin
                if (cur_nil || guard_end)
                begin
                    state_next = S_YIELD;
                end
                else
                begin
                    inf_raddr  = TW'(cur_reg);
                    lnk_raddr  = TW'(cur_reg);
                    state_next = S_W_CHK;
                end
            end

            // Expired sleepers are queued, the rest are pushed onto a fresh list.
            S_W_CHK:
            begin
                guard_next = guard_reg + NW'(1);
                cur_next   = lnk_eff;
                if (inf_eff.wake > now_reg)
                begin
                    lnk_we          = 1'b1;
                    lnk_waddr       = TW'(cur_reg);
                    lnk_wdata       = sleep_head_reg;
                    sleep_head_next = cur_reg;
                    state_next      = S_W_RD;
                end
                else
                begin
                    ap_t_next    = TW'(cur_reg);
                    ap_lv_next   = inf_eff.lv;
                    ap_wake_next = inf_eff.wake;
                    ret_next     = S_W_RD;
                    state_next   = S_AP1;
                end
            end

            S_T_CHK:
            begin
                ap_t_next    = th_reg;
                ap_lv_next   = inf_eff.lv;
                ap_wake_next = inf_eff.wake;
                if (rv_reg && running_reg == th_reg)
                begin
                    inf_we         = 1'b1;
                    inf_waddr      = th_reg;
                    inf_wdata.wake = inf_eff.wake;
                    inf_wdata.lv   = inf_eff.lv;
                    inf_wdata.plc  = PL_UNQUEUED;
                    rv_next        = 1'b0;
                    status_next    = ST_SELF_TERM;
                    report_next    = 1'b1;
                    state_next     = S_DONE;
                end
                else if (inf_eff.plc == PL_READY || inf_eff.plc == PL_SLEEPING)
                begin
                    u_ready_next = (inf_eff.plc == PL_READY);
                    cur_next     = (inf_eff.plc == PL_READY) ? head_reg[inf_eff.lv] :
                                   sleep_head_reg;
                    prev_next    = NIL;
                    guard_next   = '0;
                    state_next   = S_U_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_U_RD:
            begin
                if (cur_nil || guard_end)
                begin
                    state_next = S_U_FIN;
                end
                else
                begin
                    lnk_raddr  = TW'(cur_reg);
                    state_next = S_U_CHK;
                end
            end

            S_U_CHK:
            begin
                if (cur_reg == NW'(ap_t_reg))
                begin
                    if (prev_reg < NIL)
                    begin
                        lnk_we    = 1'b1;
                        lnk_waddr = TW'(prev_reg);
                        lnk_wdata = lnk_eff;
                    end
                    else if (u_ready_reg)
                    begin
                        head_next[ap_lv_reg] = lnk_eff;
                    end
                    else
                    begin
                        sleep_head_next = lnk_eff;
                    end
                    if (u_ready_reg && tail_reg[ap_lv_reg] == NW'(ap_t_reg))
                    begin
                        tail_next[ap_lv_reg] = prev_reg;
                    end
                    state_next = S_U_FIN;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = lnk_eff;
                    guard_next = guard_reg + NW'(1);
                    state_next = S_U_RD;
                end
            end

            S_U_FIN:
            begin
                lnk_we         = 1'b1;
                lnk_waddr      = ap_t_reg;
                lnk_wdata      = NIL;
                inf_we         = 1'b1;
                inf_waddr      = ap_t_reg;
                inf_wdata.wake = ap_wake_reg;
                inf_wdata.lv   = ap_lv_reg;
                inf_wdata.plc  = PL_UNQUEUED;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, status_reg,
                                      report_reg ? th_raw_reg : THREAD_W'(running_reg)};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        inf_vld_next = inf_vld_reg;
        lnk_vld_next = lnk_vld_reg;
        if (inf_we)
        begin
            inf_vld_next[inf_waddr] = 1'b1;
        end
        if (lnk_we)
        begin
            lnk_vld_next[lnk_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_DONE;
            dprio_reg      <= DEFAULT_PRIO_RST;
            rate_reg       <= TICK_RATE_RST;
            for (int i = 0; i < PRIO_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            sleep_head_reg <= NIL;
            running_reg    <= '0;
            rv_reg         <= 1'b1;
            status_reg     <= ST_OK;
            report_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            inf_vld_reg    <= '0;
            lnk_vld_reg    <= '0;
            inf_rv_reg     <= 1'b0;
            lnk_rv_reg     <= 1'b0;
            inf_ra_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            if (apb_wr)
            begin
                if (paddr[2] == REG_TICK_RATE)
                begin
                    rate_reg <= pwdata[RATE_W-1:0];
                end
                else
                begin
                    dprio_reg <= pwdata[PRIO_W-1:0];
                end
            end
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            sleep_head_reg <= sleep_head_next;
            running_reg    <= running_next;
            rv_reg         <= rv_next;
            status_reg     <= status_next;
            report_reg     <= report_next;
            out_valid_reg  <= out_valid_next;
            inf_vld_reg    <= inf_vld_next;
            lnk_vld_reg    <= lnk_vld_next;
            inf_rv_reg     <= inf_vld_reg[inf_raddr];
            lnk_rv_reg     <= lnk_vld_reg[lnk_raddr];
            inf_ra_reg     <= inf_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        th_raw_reg   <= th_raw_next;
        th_reg       <= th_next;
        preq_reg     <= preq_next;
        now_reg      <= now_next;
        ap_t_reg     <= ap_t_next;
        ap_lv_reg    <= ap_lv_next;
        ap_wake_reg  <= ap_wake_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        guard_reg    <= guard_next;
        u_ready_reg  <= u_ready_next;
        out_data_reg <= out_data_next;
    end

    // A level's head and tail are empty together whenever no request is in flight.
    a_queue_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ht_ok)
        else $error("ready queue head and tail disagree on emptiness");

    // The tick unit only finishes while a sleep request waits for it.
    a_tick_owner: assert property (@(posedge clk) disable iff (!rst_n)
        tick_done |-> (state_reg == S_SL_M))
        else $error("wake tick delivered outside a sleep request");

    // A list walk never runs past the number of thread slots.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_U_RD || state_reg == S_W_RD) |-> (guard_reg <= NW'(MAX_THREADS)))
        else $error("list walk exceeded thread count");

endmodule
